/* hw/rtl/i2c_master_bit_engine_macros.svh */
// Assertion macros for the I2C master bit engine.
// Used by the top level only; expects a clk and rst in scope.
`ifndef I2C_MASTER_BIT_ENGINE_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_MACROS_SVH

// same-cycle implication
`define I2CM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("i2cm assertion failed");

// next-cycle implication
`define I2CM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("i2cm assertion failed");

`endif

/* hw/rtl/i2cm_pkg.sv */
// Shared types and constants for the I2C master bit engine.
// No dependencies.
package i2cm_pkg;

  localparam int TIMER_BITS = 10;
  localparam int CFG_W = 10;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_W-1:0] CLOCK_HIGH_RESET = 10'd30;
  localparam logic [CFG_W-1:0] CLOCK_LOW_RESET = 10'd30;

  localparam int WAIT_ST_FIRST = 5;
  localparam int WAIT_ST_SHORT = 1;
  localparam int WAIT_ST_LONG = 30;
  localparam int WAIT_SP = 2;
  localparam int WAIT_SETUP = 1;
  localparam int WAIT_RB_SET = 3;
  localparam int WAIT_RB_HIGH = 30;
  localparam int WAIT_RB_LOW = 20;
  localparam int BITS_PER_BYTE = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CLOCK_HIGH = 1'b0,
    REG_CLOCK_LOW  = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [14:0] {
    PH_IDLE    = 15'h0001,
    PH_ST_A    = 15'h0002,
    PH_ST_B    = 15'h0004,
    PH_ST_C    = 15'h0008,
    PH_ST_D    = 15'h0010,
    PH_ST_E    = 15'h0020,
    PH_SP_A    = 15'h0040,
    PH_SP_B    = 15'h0080,
    PH_SP_C    = 15'h0100,
    PH_TB_SET  = 15'h0200,
    PH_TB_HIGH = 15'h0400,
    PH_TB_LOW  = 15'h0800,
    PH_RB_SET  = 15'h1000,
    PH_RB_HIGH = 15'h2000,
    PH_RB_LOW  = 15'h4000
  } phase_t;

  typedef struct packed {
    logic       mode;
    cmd_t       command;
    logic [7:0] tx_byte;
    logic       ack_to_send;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_data;
    logic       ack_seen;
    logic       command_rejected;
  } result_t;

  typedef struct packed {
    logic load;
    logic dec;
    logic clear;
  } timer_ctl_t;

  typedef struct packed {
    logic busy;
  } seq_status_t;

endpackage

/* hw/rtl/i2cm_timer.sv */
// Phase wait timer: load, count down, flag the last tick of a wait.
// Depends on i2cm_pkg.
module i2cm_timer
  import i2cm_pkg::*;
#(
  parameter int TimerBits = TIMER_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  timer_ctl_t           ctl,
  input  logic [TimerBits-1:0] load_value,
  output logic                 expire
);

  logic [TimerBits-1:0] count;
  logic [TimerBits-1:0] count_next;

  always_comb begin
    count_next = count;
    if (ctl.clear) begin
      count_next = '0;
    end else if (ctl.load) begin
      count_next = (load_value == '0) ? TimerBits'(1) : load_value;
    end else if (ctl.dec) begin
      count_next = count - TimerBits'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  assign expire = (count == TimerBits'(1));

endmodule

/* hw/rtl/i2cm_seq.sv */
// Phase sequencer and byte datapath of the I2C master bit engine.
// Depends on i2cm_pkg; drives i2cm_timer through a timer_ctl_t.
module i2cm_seq
  import i2cm_pkg::*;
#(
  parameter int TimerBits = TIMER_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  item_t                item,
  input  logic [CFG_W-1:0]     clock_high,
  input  logic [CFG_W-1:0]     clock_low,
  input  logic                 expire,
  output timer_ctl_t           tctl,
  output logic [TimerBits-1:0] load_value,
  output result_t              res,
  output seq_status_t          status
);

  phase_t     phase, phase_next;
  logic [7:0] shift_reg, shift_reg_next;
  logic [3:0] bit_count, bit_count_next;
  logic       scl, scl_next;
  logic       sda_drive, sda_drive_next;
  logic       ack, ack_next;
  logic [7:0] rx, rx_next;
  cmd_t       active_cmd, active_cmd_next;
  logic       ack_out, ack_out_next;
  logic       done;
  logic       rejected;
  logic [3:0] bit_inc;
  logic [7:0] shift_up;

  assign bit_inc  = bit_count + 4'd1;
  assign shift_up = {shift_reg[6:0], 1'b0};

  always_comb begin
    phase_next      = phase;
    shift_reg_next  = shift_reg;
    bit_count_next  = bit_count;
    scl_next        = scl;
    sda_drive_next  = sda_drive;
    ack_next        = ack;
    rx_next         = rx;
    active_cmd_next = active_cmd;
    ack_out_next    = ack_out;
    done            = 1'b0;
    rejected        = 1'b0;
    tctl            = '0;
    load_value      = '0;
    if (step) begin
      if (item.mode) begin
        if (phase != PH_IDLE) begin
          rejected = 1'b1;
        end else begin
          active_cmd_next = item.command;
          tctl.load = 1'b1;
          unique case (item.command)
            CMD_START: begin
              phase_next = PH_ST_A;
              load_value = TimerBits'(WAIT_ST_FIRST);
            end
            CMD_STOP: begin
              scl_next   = 1'b0;
              phase_next = PH_SP_A;
              load_value = TimerBits'(WAIT_SP);
            end
            CMD_WRITE: begin
              shift_reg_next = item.tx_byte;
              bit_count_next = 4'd0;
              sda_drive_next = ~item.tx_byte[7];
              phase_next     = PH_TB_SET;
              load_value     = TimerBits'(WAIT_SETUP);
            end
            default: begin
              shift_reg_next = 8'd0;
              bit_count_next = 4'd0;
              ack_out_next   = item.ack_to_send;
              sda_drive_next = 1'b0;
              phase_next     = PH_RB_SET;
              load_value     = TimerBits'(WAIT_RB_SET);
            end
          endcase
        end
      end else if (phase != PH_IDLE) begin
        if (!expire) begin
          tctl.dec = 1'b1;
        end else begin
          tctl.load = 1'b1;
          unique case (phase)
            PH_ST_A: begin
              sda_drive_next = 1'b0;
              phase_next     = PH_ST_B;
              load_value     = TimerBits'(WAIT_ST_SHORT);
            end
            PH_ST_B: begin
              scl_next   = 1'b1;
              phase_next = PH_ST_C;
              load_value = TimerBits'(WAIT_ST_LONG);
            end
            PH_ST_C: begin
              sda_drive_next = 1'b1;
              phase_next     = PH_ST_D;
              load_value     = TimerBits'(WAIT_ST_LONG);
            end
            PH_ST_D: begin
              scl_next   = 1'b0;
              phase_next = PH_ST_E;
              load_value = TimerBits'(WAIT_ST_LONG);
            end
            PH_SP_A: begin
              sda_drive_next = 1'b1;
              phase_next     = PH_SP_B;
              load_value     = TimerBits'(WAIT_SP);
            end
            PH_SP_B: begin
              scl_next   = 1'b1;
              phase_next = PH_SP_C;
              load_value = TimerBits'(WAIT_SP);
            end
            PH_SP_C: begin
              sda_drive_next = 1'b0;
              done           = 1'b1;
            end
            PH_TB_SET: begin
              scl_next   = 1'b1;
              phase_next = PH_TB_HIGH;
              load_value = TimerBits'(clock_high);
            end
            PH_TB_HIGH: begin
              scl_next   = 1'b0;
              phase_next = PH_TB_LOW;
              load_value = TimerBits'(clock_low);
            end
            PH_TB_LOW: begin
              if (active_cmd == CMD_WRITE) begin
                bit_count_next = bit_inc;
                shift_reg_next = shift_up;
                if (bit_inc < 4'(BITS_PER_BYTE)) begin
                  sda_drive_next = ~shift_up[7];
                  phase_next     = PH_TB_SET;
                  load_value     = TimerBits'(WAIT_SETUP);
                end else begin
                  sda_drive_next = 1'b0;
                  phase_next     = PH_RB_SET;
                  load_value     = TimerBits'(WAIT_RB_SET);
                end
              end else begin
                rx_next = shift_reg;
                done    = 1'b1;
              end
            end
            PH_RB_SET: begin
              scl_next   = 1'b1;
              phase_next = PH_RB_HIGH;
              load_value = TimerBits'(WAIT_RB_HIGH);
            end
            PH_RB_HIGH: begin
              if (active_cmd == CMD_WRITE) begin
                ack_next = item.sda_in;
              end else begin
                shift_reg_next = {shift_reg[6:0], item.sda_in};
                bit_count_next = bit_inc;
              end
              scl_next   = 1'b0;
              phase_next = PH_RB_LOW;
              load_value = TimerBits'(WAIT_RB_LOW);
            end
            PH_RB_LOW: begin
              if (active_cmd == CMD_READ) begin
                if (bit_count < 4'(BITS_PER_BYTE)) begin
                  sda_drive_next = 1'b0;
                  phase_next     = PH_RB_SET;
                  load_value     = TimerBits'(WAIT_RB_SET);
                end else begin
                  sda_drive_next = ~ack_out;
                  phase_next     = PH_TB_SET;
                  load_value     = TimerBits'(WAIT_SETUP);
                end
              end else begin
                done = 1'b1;
              end
            end
            default: begin
              done = 1'b1;
            end
          endcase
          if (done) begin
            tctl.load  = 1'b0;
            tctl.clear = 1'b1;
            phase_next = PH_IDLE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      shift_reg  <= '0;
      bit_count  <= '0;
      scl        <= 1'b1;
      sda_drive  <= 1'b0;
      ack        <= 1'b0;
      rx         <= '0;
      active_cmd <= CMD_START;
      ack_out    <= 1'b0;
    end else begin
      phase      <= phase_next;
      shift_reg  <= shift_reg_next;
      bit_count  <= bit_count_next;
      scl        <= scl_next;
      sda_drive  <= sda_drive_next;
      ack        <= ack_next;
      rx         <= rx_next;
      active_cmd <= active_cmd_next;
      ack_out    <= ack_out_next;
    end
  end

  always_comb begin
    res.scl_level        = scl_next;
    res.sda_pull_low     = sda_drive_next;
    res.busy_res         = (phase_next != PH_IDLE);
    res.done_res         = done;
    res.rx_data          = rx_next;
    res.ack_seen         = ack_next;
    res.command_rejected = rejected;
  end

  assign status.busy = (phase != PH_IDLE);

endmodule

/* hw/rtl/i2c_master_bit_engine.sv */
// Top level of the I2C master bit engine: input register, sequencer, result register.
// Depends on i2cm_pkg, i2cm_timer, i2cm_seq and i2c_master_bit_engine_macros.svh.
//
//  channel  | direction | payload
//  s_axis   | in        | one tick or command word, tuser = mode
//  m_axis   | out       | one result word per input word
//  cfg      | in        | register index and write data
//
// One word per cycle sustained while m_axis is ready; a taken word's result is registered.
// Each word does at most one timer step or one phase advance between the two registers.
// A stalled m_axis holds the result register; one more word waits in the input register.
// Synchronous reset clears both valid flags, the phase state and the timer.
// cfg_ready is always high; registers take effect on the next word.
`include "i2c_master_bit_engine_macros.svh"

module i2c_master_bit_engine
  import i2cm_pkg::*;
#(
  parameter int TimerBits = TIMER_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [1:0] command, [9:2] tx_byte, [10] ack_to_send, [11] sda_in, [15:12] zero
  input  logic [15:0]            s_axis_tdata,
  // [0] mode
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [0] scl_level, [1] sda_pull_low, [2] busy_res, [3] done_res,
  // [11:4] rx_data, [12] ack_seen, [13] command_rejected, [15:14] zero
  output logic [15:0]            m_axis_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  logic                 in_valid;
  item_t                in_item;
  logic                 out_valid;
  result_t              out_res;
  logic                 advance;
  logic                 step;
  logic [CFG_W-1:0]     clock_high;
  logic [CFG_W-1:0]     clock_low;
  timer_ctl_t           tctl;
  logic [TimerBits-1:0] load_value;
  logic                 expire;
  result_t              res;
  seq_status_t          status;

  assign advance       = !out_valid || m_axis_tready;
  assign step          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_high <= CLOCK_HIGH_RESET;
      clock_low  <= CLOCK_LOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_CLOCK_HIGH: clock_high <= cfg_data;
        default:        clock_low  <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.mode        <= s_axis_tuser;
      in_item.command     <= cmd_t'(s_axis_tdata[1:0]);
      in_item.tx_byte     <= s_axis_tdata[9:2];
      in_item.ack_to_send <= s_axis_tdata[10];
      in_item.sda_in      <= s_axis_tdata[11];
    end
  end

  i2cm_timer #(
    .TimerBits(TimerBits)
  ) u_timer (
    .clk       (clk),
    .rst       (rst),
    .ctl       (tctl),
    .load_value(load_value),
    .expire    (expire)
  );

  i2cm_seq #(
    .TimerBits(TimerBits)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (in_item),
    .clock_high(clock_high),
    .clock_low (clock_low),
    .expire    (expire),
    .tctl      (tctl),
    .load_value(load_value),
    .res       (res),
    .status    (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_res.command_rejected, out_res.ack_seen, out_res.rx_data,
                          out_res.done_res, out_res.busy_res, out_res.sda_pull_low,
                          out_res.scl_level};

  `I2CM_ASSERT_NOW(a_done_ends_busy, out_valid && out_res.done_res,
                   !out_res.busy_res && !out_res.command_rejected)
  `I2CM_ASSERT_NEXT(a_cmd_starts_busy, step && in_item.mode && !status.busy, status.busy)
  `I2CM_ASSERT_NEXT(a_idle_tick_stays, step && !in_item.mode && !status.busy, !status.busy)

endmodule

/* bench/i2c_master_bit_engine_checker.sv */
// Scoreboard for the I2C master bit engine: follows the stream and register channels,
// predicts each result word from its own copy of the engine and compares field by field.
// Depends on i2cm_pkg.
module i2c_master_bit_engine_checker
  import i2cm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [15:0]            s_axis_tdata,
  input  logic                   s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [15:0]            m_axis_tdata,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  output int                     fail_count,
  output int                     pending,
  output int                     words_seen,
  output int                     cmds_done,
  output int                     cmds_refused
);

  phase_t                ph;
  logic [TIMER_BITS-1:0] wait_left;
  logic [7:0]            shreg;
  logic [3:0]            nbits;
  logic                  scl_q;
  logic                  sda_q;
  logic                  ack_q;
  logic [7:0]            rx_q;
  cmd_t                  cur_cmd;
  logic                  ack_out_q;
  logic [CFG_W-1:0]      high_q;
  logic [CFG_W-1:0]      low_q;

  result_t bus_word_q[$];
  int      mism;
  int      n_words;
  int      n_done;
  int      n_refused;

  function automatic void arm_wait(phase_t nxt, int unsigned ticks);
    logic [TIMER_BITS-1:0] t;
    t = ticks[TIMER_BITS-1:0];
    if (t == '0) t = TIMER_BITS'(1);
    ph = nxt;
    wait_left = t;
  endfunction

  function automatic void drive_bit(logic level);
    sda_q = ~level;
    arm_wait(PH_TB_SET, WAIT_SETUP);
  endfunction

  function automatic void release_for_sample();
    sda_q = 1'b0;
    arm_wait(PH_RB_SET, WAIT_RB_SET);
  endfunction

  function automatic bit step_phase(logic sda);
    case (ph)
      PH_ST_A: begin
        sda_q = 1'b0;
        arm_wait(PH_ST_B, WAIT_ST_SHORT);
      end
      PH_ST_B: begin
        scl_q = 1'b1;
        arm_wait(PH_ST_C, WAIT_ST_LONG);
      end
      PH_ST_C: begin
        sda_q = 1'b1;
        arm_wait(PH_ST_D, WAIT_ST_LONG);
      end
      PH_ST_D: begin
        scl_q = 1'b0;
        arm_wait(PH_ST_E, WAIT_ST_LONG);
      end
      PH_SP_A: begin
        sda_q = 1'b1;
        arm_wait(PH_SP_B, WAIT_SP);
      end
      PH_SP_B: begin
        scl_q = 1'b1;
        arm_wait(PH_SP_C, WAIT_SP);
      end
      PH_SP_C: begin
        sda_q = 1'b0;
        return 1'b1;
      end
      PH_TB_SET: begin
        scl_q = 1'b1;
        arm_wait(PH_TB_HIGH, 32'(high_q));
      end
      PH_TB_HIGH: begin
        scl_q = 1'b0;
        arm_wait(PH_TB_LOW, 32'(low_q));
      end
      PH_TB_LOW: begin
        if (cur_cmd != CMD_WRITE) begin
          rx_q = shreg;
          return 1'b1;
        end
        nbits = nbits + 4'd1;
        shreg = shreg << 1;
        if (nbits < 4'(BITS_PER_BYTE)) drive_bit(shreg[7]);
        else release_for_sample();
      end
      PH_RB_SET: begin
        scl_q = 1'b1;
        arm_wait(PH_RB_HIGH, WAIT_RB_HIGH);
      end
      PH_RB_HIGH: begin
        if (cur_cmd == CMD_WRITE) begin
          ack_q = sda;
        end else begin
          shreg = {shreg[6:0], sda};
          nbits = nbits + 4'd1;
        end
        scl_q = 1'b0;
        arm_wait(PH_RB_LOW, WAIT_RB_LOW);
      end
      PH_RB_LOW: begin
        if (cur_cmd != CMD_READ) return 1'b1;
        if (nbits < 4'(BITS_PER_BYTE)) release_for_sample();
        else drive_bit(ack_out_q);
      end
      default: return 1'b1;
    endcase
    return 1'b0;
  endfunction

  function automatic result_t run_engine(item_t it);
    result_t r;
    r = '0;
    if (it.mode) begin
      if (ph != PH_IDLE) begin
        r.command_rejected = 1'b1;
      end else begin
        cur_cmd = it.command;
        case (it.command)
          CMD_START: arm_wait(PH_ST_A, WAIT_ST_FIRST);
          CMD_STOP: begin
            scl_q = 1'b0;
            arm_wait(PH_SP_A, WAIT_SP);
          end
          CMD_WRITE: begin
            shreg = it.tx_byte;
            nbits = '0;
            drive_bit(it.tx_byte[7]);
          end
          default: begin
            shreg = '0;
            nbits = '0;
            ack_out_q = it.ack_to_send;
            release_for_sample();
          end
        endcase
      end
    end else if (ph != PH_IDLE) begin
      wait_left = wait_left - TIMER_BITS'(1);
      if (wait_left == '0) begin
        if (step_phase(it.sda_in)) begin
          ph = PH_IDLE;
          wait_left = '0;
          r.done_res = 1'b1;
        end
      end
    end
    r.scl_level = scl_q;
    r.sda_pull_low = sda_q;
    r.busy_res = (ph != PH_IDLE);
    r.rx_data = rx_q;
    r.ack_seen = ack_q;
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mism++;
    end
  endfunction

  always @(posedge clk) begin
    item_t       word_in;
    result_t     want;
    logic [15:0] got;
    if (rst) begin
      ph = PH_IDLE;
      wait_left = '0;
      shreg = '0;
      nbits = '0;
      scl_q = 1'b1;
      sda_q = 1'b0;
      ack_q = 1'b0;
      rx_q = '0;
      cur_cmd = CMD_START;
      ack_out_q = 1'b0;
      high_q = CLOCK_HIGH_RESET;
      low_q = CLOCK_LOW_RESET;
      bus_word_q.delete();
      mism = 0;
      n_words = 0;
      n_done = 0;
      n_refused = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_index_t'(cfg_index))
          REG_CLOCK_HIGH: high_q = cfg_data;
          default: low_q = cfg_data;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (bus_word_q.size() == 0) begin
          $error("result word %h arrived with no prediction waiting", got);
          mism++;
        end else begin
          want = bus_word_q.pop_front();
          check_field("scl_level", 8'(want.scl_level), 8'(got[0]));
          check_field("sda_pull_low", 8'(want.sda_pull_low), 8'(got[1]));
          check_field("busy_res", 8'(want.busy_res), 8'(got[2]));
          check_field("done_res", 8'(want.done_res), 8'(got[3]));
          check_field("rx_data", want.rx_data, got[11:4]);
          check_field("ack_seen", 8'(want.ack_seen), 8'(got[12]));
          check_field("command_rejected", 8'(want.command_rejected), 8'(got[13]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        word_in.mode = s_axis_tuser;
        word_in.command = cmd_t'(s_axis_tdata[1:0]);
        word_in.tx_byte = s_axis_tdata[9:2];
        word_in.ack_to_send = s_axis_tdata[10];
        word_in.sda_in = s_axis_tdata[11];
        want = run_engine(word_in);
        bus_word_q.push_back(want);
        n_words++;
        if (want.done_res) n_done++;
        if (want.command_rejected) n_refused++;
      end
    end
    fail_count <= mism;
    pending <= bus_word_q.size();
    words_seen <= n_words;
    cmds_done <= n_done;
    cmds_refused <= n_refused;
  end

endmodule

/* bench/i2c_master_bit_engine_test.sv */
// Top of the I2C master bit engine bench: clock, reset, command and tick stimulus,
// register writes, output back-pressure and the verdict.
// Depends on i2cm_pkg, i2c_master_bit_engine and i2c_master_bit_engine_checker.
module i2c_master_bit_engine_test;
  import i2cm_pkg::*;

  localparam int STUCK_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_WORDS = 40;
  localparam int PHASE_CMDS = 2;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [15:0]            s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [15:0]            m_axis_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_W-1:0]       cfg_data;

  int fail_count;
  int pending;
  int words_seen;
  int cmds_done;
  int cmds_refused;

  int               tx_idle_pct = 0;
  int               rx_idle_pct = 0;
  int               busy_left = 0;
  int               words_sent = 0;
  int               cmds_issued = 0;
  int               reg_writes = 0;
  int               stuck_cycles = 0;
  bit               hold_req = 1'b0;
  logic [CFG_W-1:0] high_set = CLOCK_HIGH_RESET;
  logic [CFG_W-1:0] low_set = CLOCK_LOW_RESET;

  i2c_master_bit_engine dut (.*);

  i2c_master_bit_engine_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  function automatic int ticks_for(cmd_t c);
    int h;
    int l;
    h = (high_set == '0) ? 1 : int'(high_set);
    l = (low_set == '0) ? 1 : int'(low_set);
    case (c)
      CMD_START: return WAIT_ST_FIRST + WAIT_ST_SHORT + 3 * WAIT_ST_LONG;
      CMD_STOP: return 3 * WAIT_SP;
      CMD_WRITE: return BITS_PER_BYTE * (WAIT_SETUP + h + l) +
                        WAIT_RB_SET + WAIT_RB_HIGH + WAIT_RB_LOW;
      default: return BITS_PER_BYTE * (WAIT_RB_SET + WAIT_RB_HIGH + WAIT_RB_LOW) +
                      WAIT_SETUP + h + l;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_clock();
    int r;
    r = $urandom_range(99);
    if (r < 15) return '0;
    return CFG_W'($urandom_range(4, 1));
  endfunction

  task automatic put_word(input logic mode, input cmd_t c, input logic [7:0] b,
                          input logic ack, input logic sda);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= {4'b0, sda, ack, b, c};
    do @(posedge clk); while (!s_axis_tready);
    if (mode) begin
      words_sent++;
      if (busy_left == 0) begin
        busy_left = ticks_for(c);
        cmds_issued++;
      end
    end else if (busy_left > 0) begin
      busy_left--;
      words_sent++;
    end
  endtask

  task automatic tick(input int sda_sel);
    logic sda;
    sda = (sda_sel < 0) ? 1'($urandom_range(1)) : sda_sel[0];
    put_word(1'b0, cmd_t'($urandom_range(3)), 8'($urandom_range(255)),
             1'($urandom_range(1)), sda);
  endtask

  task automatic finish_cmd(input int sda_sel, input int refuse_pct);
    while (busy_left > 0) begin
      if ($urandom_range(99) < refuse_pct)
        put_word(1'b1, cmd_t'($urandom_range(3)), 8'($urandom_range(255)),
                 1'($urandom_range(1)), 1'($urandom_range(1)));
      else
        tick(sda_sel);
    end
  endtask

  task automatic run_cmd(input cmd_t c, input logic [7:0] b, input logic ack,
                         input int sda_sel);
    put_word(1'b1, c, b, ack, 1'($urandom_range(1)));
    finish_cmd(sda_sel, 2);
    repeat ($urandom_range(2)) tick(-1);
  endtask

  task automatic settle();
    finish_cmd(-1, 0);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_clocks(input logic [CFG_W-1:0] h, input logic [CFG_W-1:0] l);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= REG_CLOCK_HIGH;
    cfg_data <= h;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_CLOCK_LOW;
    cfg_data <= l;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    high_set = h;
    low_set = l;
    reg_writes += 2;
  endtask

  task automatic random_cmd();
    cmd_t c;
    c = ($urandom_range(1) != 0) ? CMD_WRITE : CMD_STOP;
    run_cmd(c, 8'($urandom_range(255)), 1'($urandom_range(1)), -1);
  endtask

  task automatic random_phase(input int tx_pct, input int rx_pct, input bit with_hold);
    int cmd_goal;
    int word_goal;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    cmd_goal = cmds_issued + PHASE_CMDS;
    word_goal = words_sent + PHASE_WORDS;
    set_clocks(pick_clock(), pick_clock());
    if (with_hold) hold_req = 1'b1;
    while (cmds_issued < cmd_goal || words_sent < word_goal)
      random_cmd();
  endtask

  initial begin
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_CLOCK_HIGH;
    cfg_data <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    tick(-1);
    tick(-1);
    run_cmd(CMD_STOP, 8'h00, 1'b0, -1);
    set_clocks('0, '0);
    put_word(1'b1, CMD_START, 8'h00, 1'b0, 1'b0);
    repeat (10) tick(-1);
    put_word(1'b1, CMD_WRITE, 8'hff, 1'b1, 1'b1);
    finish_cmd(-1, 0);
    run_cmd(CMD_READ, 8'h00, 1'b1, -1);

    random_phase(18, 87, 1'b0);
    random_phase(87, 18, 1'b0);
    random_phase(0, 0, 1'b1);

    settle();
    repeat (10) @(posedge clk);
    $display("Covered %0d words with %0d completed and %0d refused commands,",
             words_seen, cmds_done, cmds_refused);
    $display("%0d clock register writes, stalls on both sides and a long output hold.",
             reg_writes);
    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
